>>> design/pbrgba_pkg.sv
// Shared types, constants and helpers for the PackBits planar RGBA decoder.
package pbrgba_pkg;

	// Output channel plane count and the channel that carries alpha
	localparam logic [2:0] NUM_OUT_CH = 3'd4;
	localparam logic [2:0] ALPHA_CH   = 3'd3;

	// Plane size clamp and skip channel clamp
	localparam logic [24:0] MAX_PIXELS        = 25'h100_0000;
	localparam logic [4:0]  MAX_SKIP_CHANNELS = 5'd16;

	// PackBits header that does nothing
	localparam logic [7:0] HDR_NOP = 8'd128;

	// Fill values for absent planes
	localparam logic [7:0] FILL_COLOR = 8'h00;
	localparam logic [7:0] FILL_ALPHA = 8'hFF;

	// Configuration register indexes
	localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd0;
	localparam logic [1:0] CFG_ROW_COUNT     = 2'd1;
	localparam logic [1:0] CFG_PIXEL_COUNT   = 2'd2;

	// Reset values of the configuration registers
	localparam logic [4:0]  RST_CHANNEL_COUNT = 5'd3;
	localparam logic [15:0] RST_ROW_COUNT     = 16'd1;
	localparam logic [24:0] RST_PIXEL_COUNT   = 25'd1;

	// Job queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	// One job: an optional pixel run, then optional fill runs from fill_from up to alpha.
	// fill also marks that the image completes with this job.
	typedef struct packed {
		logic        has_run;
		logic [1:0]  channel;
		logic [23:0] start_pixel;
		logic [24:0] run_count;
		logic [7:0]  byte_value;
		logic        clipped;
		logic        fill;
		logic [2:0]  fill_from;
	} job_t;

	// Pixels per plane, clamped to 1 .. MAX_PIXELS
	function automatic logic [24:0] plane_size(input logic [24:0] pixel_count);
		logic [24:0] p;
		p = pixel_count;
		if (pixel_count == '0) begin
			p = 25'd1;
		end else if (pixel_count > MAX_PIXELS) begin
			p = MAX_PIXELS;
		end
		return p;
	endfunction

	// Planes that are decoded from the stream
	function automatic logic [2:0] present_planes(input logic [4:0] channel_count);
		logic [2:0] n;
		n = NUM_OUT_CH;
		if (channel_count < {2'b00, NUM_OUT_CH}) begin
			n = channel_count[2:0];
		end
		return n;
	endfunction

endpackage

>>> design/pbrgba_front.sv
// Front: takes one byte per transfer, tracks the PackBits parse state and
// turns each byte into at most one job for the back end.
module pbrgba_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        data_byte,
	input  logic              first,
	input  logic [4:0]        channel_count,
	input  logic [15:0]       row_count,
	input  logic [24:0]       plane_px,
	output logic              push,
	output pbrgba_pkg::job_t  job
);

	typedef enum logic [2:0] {
		PH_SKIP,
		PH_HEADER,
		PH_LITERAL,
		PH_DISCARD,
		PH_REPEAT,
		PH_DONE
	} phase_t;

	phase_t      phase_q, phase_e, phase_w, phase_n;
	logic [20:0] skip_q, skip_e, skip_n;
	logic [2:0]  ch_q, ch_e, ch_n;
	logic [24:0] pos_q, pos_e, pos_n;
	logic [7:0]  lit_q, lit_e, lit_n;
	logic [7:0]  rep_q, rep_e, rep_n;

	logic [2:0]  present;
	logic [4:0]  cc_sat;
	logic [19:0] skip_prod;
	logic [20:0] skip_init;
	logic [7:0]  lit_dec;
	logic [24:0] pos_inc;
	logic [24:0] rep_ext;
	logic [24:0] rem;
	logic [24:0] cnt;
	logic [24:0] pos_rep;
	logic [2:0]  ch_inc;

	// Row-length skip size: 2 * min(channels,16) * rows
	assign cc_sat    = (channel_count > pbrgba_pkg::MAX_SKIP_CHANNELS) ?
		pbrgba_pkg::MAX_SKIP_CHANNELS : channel_count;
	assign skip_prod = 20'(cc_sat) * 20'(row_count);
	assign skip_init = {skip_prod, 1'b0};

	assign present = pbrgba_pkg::present_planes(channel_count);

	// A first mark restarts the image before the byte is processed
	assign phase_e = first ? PH_SKIP : phase_q;
	assign skip_e  = first ? skip_init : skip_q;
	assign ch_e    = first ? 3'd0 : ch_q;
	assign pos_e   = first ? 25'd0 : pos_q;
	assign lit_e   = first ? 8'd0 : lit_q;
	assign rep_e   = first ? 8'd0 : rep_q;

	// Datapath helpers
	assign lit_dec = (lit_e != 8'd0) ? (lit_e - 8'd1) : lit_e;
	assign pos_inc = pos_e + 25'd1;
	assign rep_ext = {17'd0, rep_e};
	assign rem     = plane_px - pos_e;
	assign cnt     = (rep_ext < rem) ? rep_ext : rem;
	assign pos_rep = pos_e + cnt;
	assign ch_inc  = ch_e + 3'd1;
	assign phase_w = (phase_e == PH_SKIP) ? PH_HEADER : phase_e;

	// Next state and job for the current byte
	always_comb begin
		phase_n = phase_e;
		skip_n  = skip_e;
		ch_n    = ch_e;
		pos_n   = pos_e;
		lit_n   = lit_e;
		rep_n   = rep_e;
		job     = '0;

		if (phase_e == PH_SKIP && skip_e != '0) begin
			skip_n = skip_e - 21'd1;
		end else begin
			phase_n = phase_w;
			if (phase_w == PH_DISCARD) begin
				// tail of a literal that ran past the plane end
				lit_n = lit_dec;
				if (lit_dec == 8'd0) begin
					phase_n = PH_HEADER;
				end
			end else if (phase_w == PH_DONE) begin
				// image complete, byte ignored
			end else if (ch_e >= present) begin
				// channel no longer present: fill from here
				job.fill      = 1'b1;
				job.fill_from = ch_e;
				ch_n          = pbrgba_pkg::NUM_OUT_CH;
				pos_n         = '0;
				phase_n       = PH_DONE;
			end else if (pos_e >= plane_px) begin
				// plane already full: close it, byte ignored
				ch_n    = ch_inc;
				pos_n   = '0;
				phase_n = PH_HEADER;
				if (ch_inc >= present) begin
					job.fill      = 1'b1;
					job.fill_from = ch_inc;
					ch_n          = pbrgba_pkg::NUM_OUT_CH;
					phase_n       = PH_DONE;
				end
			end else begin
				unique case (phase_w)
					PH_HEADER: begin
						if (data_byte < pbrgba_pkg::HDR_NOP) begin
							lit_n   = data_byte + 8'd1;
							phase_n = PH_LITERAL;
						end else if (data_byte > pbrgba_pkg::HDR_NOP) begin
							rep_n   = 8'(9'd257 - {1'b0, data_byte});
							phase_n = PH_REPEAT;
						end
					end
					PH_LITERAL: begin
						lit_n           = lit_dec;
						job.has_run     = 1'b1;
						job.channel     = ch_e[1:0];
						job.start_pixel = pos_e[23:0];
						job.run_count   = 25'd1;
						job.byte_value  = data_byte;
						job.clipped     = (pos_inc >= plane_px) && (lit_dec != 8'd0);
						if (pos_inc >= plane_px) begin
							ch_n    = ch_inc;
							pos_n   = '0;
							phase_n = PH_HEADER;
							if (ch_inc >= present) begin
								job.fill      = 1'b1;
								job.fill_from = ch_inc;
								ch_n          = pbrgba_pkg::NUM_OUT_CH;
								phase_n       = PH_DONE;
							end else if (lit_dec != 8'd0) begin
								phase_n = PH_DISCARD;
							end
						end else begin
							pos_n = pos_inc;
							if (lit_dec == 8'd0) begin
								phase_n = PH_HEADER;
							end
						end
					end
					PH_REPEAT: begin
						job.has_run     = 1'b1;
						job.channel     = ch_e[1:0];
						job.start_pixel = pos_e[23:0];
						job.run_count   = cnt;
						job.byte_value  = data_byte;
						job.clipped     = rep_ext > rem;
						phase_n         = PH_HEADER;
						if (pos_rep >= plane_px) begin
							ch_n  = ch_inc;
							pos_n = '0;
							if (ch_inc >= present) begin
								job.fill      = 1'b1;
								job.fill_from = ch_inc;
								ch_n          = pbrgba_pkg::NUM_OUT_CH;
								phase_n       = PH_DONE;
							end
						end else begin
							pos_n = pos_rep;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Only jobs that yield at least one result enter the queue
	assign push = accept && (job.has_run ||
		(job.fill && job.fill_from != pbrgba_pkg::NUM_OUT_CH));

	// Parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			skip_q  <= '0;
			ch_q    <= '0;
			pos_q   <= '0;
			lit_q   <= '0;
			rep_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			skip_q  <= skip_n;
			ch_q    <= ch_n;
			pos_q   <= pos_n;
			lit_q   <= lit_n;
			rep_q   <= rep_n;
		end
	end

endmodule

>>> design/pbrgba_queue.sv
// Small job FIFO between front and back.
module pbrgba_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pbrgba_pkg::job_t  push_job,
	input  logic              pop,
	output pbrgba_pkg::job_t  head_job,
	output logic              empty,
	output logic              full
);

	localparam int unsigned PW = pbrgba_pkg::QPTR_W;

	pbrgba_pkg::job_t entry_q [pbrgba_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == (PW+1)'(pbrgba_pkg::QUEUE_DEPTH));
	assign head_job = entry_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

>>> design/pbrgba_back.sv
// Back: expands the head job into result runs, one per cycle while
// out_stall is low, into the output register.
module pbrgba_back (
	input  logic              clk,
	input  logic              arst_n,
	input  pbrgba_pkg::job_t  head_job,
	input  logic              empty,
	input  logic [24:0]       plane_px,
	input  logic              out_stall,
	output logic              pop,
	output logic              out_valid,
	output logic [1:0]        channel,
	output logic [23:0]       start_pixel,
	output logic [24:0]       run_count,
	output logic [7:0]        byte_value,
	output logic              clipped,
	output logic              image_done,
	output logic              last
);

	logic        run_sent_q;
	logic [1:0]  adv_q;
	logic        out_valid_q;
	logic [1:0]  channel_q;
	logic [23:0] start_pixel_q;
	logic [24:0] run_count_q;
	logic [7:0]  byte_value_q;
	logic        clipped_q;
	logic        image_done_q;
	logic        last_q;

	logic        is_run;
	logic [2:0]  fill_ch;
	logic        is_last;
	logic        load;

	// Pick the next result of the head job
	assign is_run  = head_job.has_run && !run_sent_q;
	assign fill_ch = head_job.fill_from + {1'b0, adv_q};
	assign is_last = is_run ?
		!(head_job.fill && head_job.fill_from != pbrgba_pkg::NUM_OUT_CH) :
		(fill_ch == pbrgba_pkg::ALPHA_CH);
	assign load    = !empty && (!out_valid_q || !out_stall);
	assign pop     = load && is_last;

	// Control: output valid and position within the job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			run_sent_q  <= 1'b0;
			adv_q       <= '0;
		end else begin
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= !empty;
			end
			if (load) begin
				if (is_last) begin
					run_sent_q <= 1'b0;
					adv_q      <= '0;
				end else if (is_run) begin
					run_sent_q <= 1'b1;
				end else begin
					adv_q <= adv_q + 2'd1;
				end
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			if (is_run) begin
				channel_q     <= head_job.channel;
				start_pixel_q <= head_job.start_pixel;
				run_count_q   <= head_job.run_count;
				byte_value_q  <= head_job.byte_value;
				clipped_q     <= head_job.clipped;
			end else begin
				channel_q     <= fill_ch[1:0];
				start_pixel_q <= '0;
				run_count_q   <= plane_px;
				byte_value_q  <= (fill_ch == pbrgba_pkg::ALPHA_CH) ?
					pbrgba_pkg::FILL_ALPHA : pbrgba_pkg::FILL_COLOR;
				clipped_q     <= 1'b0;
			end
			image_done_q <= is_last && head_job.fill;
			last_q       <= is_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign channel     = channel_q;
	assign start_pixel = start_pixel_q;
	assign run_count   = run_count_q;
	assign byte_value  = byte_value_q;
	assign clipped     = clipped_q;
	assign image_done  = image_done_q;
	assign last        = last_q;

endmodule

>>> design/packbits_planar_rgba_decoder.sv
// Channel  | Handshake                  | Payload
// ---------+----------------------------+--------------------------------------------
// in       | in_valid / in_stall        | data_byte, first
// out      | out_valid / out_stall      | channel, start_pixel, run_count,
//          |                            | byte_value, clipped, image_done, last
// cfg      | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; the front parse loop
// computes its next state combinationally and queues at most one job per byte.
// The back end emits one run per cycle while out_stall is low; a byte that
// completes the image can yield up to four runs, which it emits in turn.
// A result passes through the job queue and then the output register; the
// 4-entry job queue absorbs bursts and in_stall rises only when it is full.
// Reset is asynchronous and clears parse state, queue and output valid.
// cfg_ready is always high.
module packbits_planar_rgba_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        first,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  channel,
	output logic [23:0] start_pixel,
	output logic [24:0] run_count,
	output logic [7:0]  byte_value,
	output logic        clipped,
	output logic        image_done,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [24:0] cfg_data
);

	logic [4:0]  channel_count_q;
	logic [15:0] row_count_q;
	logic [24:0] pixel_count_q;
	logic [24:0] plane_px;

	logic              accept;
	logic              push;
	logic              pop;
	logic              q_empty;
	logic              q_full;
	pbrgba_pkg::job_t  push_job;
	pbrgba_pkg::job_t  head_job;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= pbrgba_pkg::RST_CHANNEL_COUNT;
			row_count_q     <= pbrgba_pkg::RST_ROW_COUNT;
			pixel_count_q   <= pbrgba_pkg::RST_PIXEL_COUNT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pbrgba_pkg::CFG_CHANNEL_COUNT: channel_count_q <= cfg_data[4:0];
				pbrgba_pkg::CFG_ROW_COUNT:     row_count_q     <= cfg_data[15:0];
				pbrgba_pkg::CFG_PIXEL_COUNT:   pixel_count_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign plane_px = pbrgba_pkg::plane_size(pixel_count_q);

	// Input transfer
	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	pbrgba_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (data_byte),
		.first         (first),
		.channel_count (channel_count_q),
		.row_count     (row_count_q),
		.plane_px      (plane_px),
		.push          (push),
		.job           (push_job)
	);

	pbrgba_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.empty    (q_empty),
		.full     (q_full)
	);

	pbrgba_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_job    (head_job),
		.empty       (q_empty),
		.plane_px    (plane_px),
		.out_stall   (out_stall),
		.pop         (pop),
		.out_valid   (out_valid),
		.channel     (channel),
		.start_pixel (start_pixel),
		.run_count   (run_count),
		.byte_value  (byte_value),
		.clipped     (clipped),
		.image_done  (image_done),
		.last        (last)
	);

endmodule

>>> design/pbrgba_checker.sv
// Port-level checks on the decoder output.
module pbrgba_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  channel,
	input logic [23:0] start_pixel,
	input logic [24:0] run_count,
	input logic [7:0]  byte_value,
	input logic        image_done,
	input logic        last
);

	// Image completion closes the byte's results
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_done |-> last)
		else $error("image_done without last");

	// The completing run always lands in the alpha plane
	a_done_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_done |-> {1'b0, channel} == pbrgba_pkg::ALPHA_CH)
		else $error("image_done on a non-alpha run");

	// Every run covers at least one pixel
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> run_count != 25'd0)
		else $error("empty run");

	// A stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(channel) &&
		$stable(start_pixel) && $stable(run_count) && $stable(byte_value))
		else $error("stalled result changed");

endmodule

bind packbits_planar_rgba_decoder pbrgba_checker u_pbrgba_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.channel     (channel),
	.start_pixel (start_pixel),
	.run_count   (run_count),
	.byte_value  (byte_value),
	.image_done  (image_done),
	.last        (last)
);
